[sv/rotated_gaussian_2d_residual_macros.svh]
// Assertion macros for the rotated Gaussian residual block.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef ROTATED_GAUSSIAN_2D_RESIDUAL_MACROS_SVH
`define ROTATED_GAUSSIAN_2D_RESIDUAL_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define RG2D_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rg2d: same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define RG2D_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rg2d: next-cycle check failed");

`endif

[sv/rg2d_pkg.sv]
// Shared constants, register codes, stage types and helpers of the rotated Gaussian residual.
// No dependencies.
package rg2d_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int ANGLE_W     = 26;
	localparam int CFG_IDX_W   = 3;
	localparam int SC_TERMS    = 6;
	localparam int EX_TERMS    = 12;
	localparam int DIV_BITS    = 30;
	localparam int EXP_SH_BITS = 5;

	localparam longint DEG2RAD_Q32 = 64'd74961320;
	localparam longint LN2_Q30     = 64'd744261118;
	localparam longint Q30_ONE     = 64'd1 << 30;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_OFFSET    = 3'd0,
		REG_PEAK_AMPLITUDE = 3'd1,
		REG_CENTER_X       = 3'd2,
		REG_CENTER_Y       = 3'd3,
		REG_WIDTH_X        = 3'd4,
		REG_WIDTH_Y        = 3'd5,
		REG_ROTATION       = 3'd6
	} cfg_reg_t;

	// One beat of point coordinates on its way to the rotation.
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
	} point_t;

	// Values that ride alongside the whole pipeline.
	typedef struct packed {
		logic signed [31:0] meas;
		logic               last;
	} side_t;

	// One stage of the sine and cosine series.
	typedef struct packed {
		logic [31:0]        t_s;
		logic [31:0]        t_c;
		logic [31:0]        n_s;
		logic [31:0]        n_c;
		logic [31:0]        q_s;
		logic [31:0]        q_c;
		logic signed [33:0] acc_s;
		logic signed [33:0] acc_c;
		logic [31:0]        x2;
		logic [1:0]         quad;
	} sc_stage_t;

	// One stage of the two restoring dividers.
	typedef struct packed {
		logic [60:0] r_x;
		logic [60:0] r_y;
		logic [29:0] q_x;
		logic [29:0] q_y;
		logic        sat_x;
		logic        sat_y;
	} dv_stage_t;

	// One stage of the ln2 range reduction.
	typedef struct packed {
		logic [38:0] r;
		logic [4:0]  sh;
		logic        big;
	} nx_stage_t;

	// One stage of the exponential series.
	typedef struct packed {
		logic [31:0]        term;
		logic [31:0]        n;
		logic [31:0]        q0;
		logic signed [33:0] acc;
		logic [29:0]        rem;
		logic [4:0]         sh;
		logic               big;
	} ex_stage_t;

	// Divisor of the k-th sine term.
	function automatic longint sin_div(input int k);
		return longint'(2 * k) * longint'(2 * k + 1);
	endfunction

	// Divisor of the k-th cosine term.
	function automatic longint cos_div(input int k);
		return longint'(2 * k - 1) * longint'(2 * k);
	endfunction

	// Clamp a series sum into [0, 1.0] in Q30.
	function automatic logic [30:0] clamp_q30(input logic signed [33:0] v);
		logic [30:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > 34'(Q30_ONE)) begin
			r = 31'(Q30_ONE);
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

endpackage

[sv/rotated_gaussian_2d_residual.sv]
// Top level of the rotated Gaussian residual: configuration registers and the full pipeline.
// Depends on rg2d_pkg and rotated_gaussian_2d_residual_macros.svh.
`include "rotated_gaussian_2d_residual_macros.svh"

// A point is taken on every cycle that start is high (busy is always low) and its residual
// appears with result_valid at the end of the pipeline; one result leaves per cycle and the
// receiver cannot stall it. Most of the pipeline is made of the 30-stage restoring dividers
// for the normalised distances and the term-by-term stages of the sine, cosine and
// exponential series, three stages per term. Configuration must only be written
// while no point is in flight; sine and cosine are recomputed for every point from the
// rotation register, so a point may follow a write on the next cycle.
module rotated_gaussian_2d_residual (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [31:0]              point_x,
	input  logic signed [31:0]              point_y,
	input  logic signed [31:0]              measured_value,
	input  logic                            last_point,
	input  logic                            cfg_wr_en,
	input  logic [rg2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rg2d_pkg::DATA_W-1:0]     cfg_data,
	output logic                            result_valid,
	output logic signed [31:0]              residual,
	output logic                            range_flag,
	output logic                            last_result
);
	import rg2d_pkg::*;

	// Angle reduction constants.
	localparam longint FULL     = longint'(360) << FRAC_BITS;
	localparam longint QUARTER  = longint'(90) << FRAC_BITS;
	localparam longint ANG_SPAN = longint'(1) << (ANGLE_W - 1);
	localparam longint WRAPS    = (ANG_SPAN + FULL - 1) / FULL;
	localparam longint OFFS     = WRAPS * FULL;
	localparam int     UA_W     = ANGLE_W + 10;
	localparam longint M_ANG    = (longint'(1) << UA_W) / FULL;
	localparam int     D_W      = $clog2(FULL);
	localparam int     D1_W     = D_W + 1;
	localparam int     R_W      = $clog2(QUARTER);
	localparam int     XP_W     = R_W + 27;
	localparam longint LN2_BIG  = LN2_Q30 * 31;

	localparam int SC_LAT = 6 + 3 * SC_TERMS + 1;
	localparam int LAT    = SC_LAT + 4 + DIV_BITS + 3 + EXP_SH_BITS + 3 * EX_TERMS + 4;

	localparam logic signed [35:0] RES_MAX = 36'sh07FFFFFFF;
	localparam logic signed [35:0] RES_MIN = -36'sh080000000;

	// Configuration registers.
	logic signed [31:0] base_offset_q;
	logic signed [31:0] peak_amplitude_q;
	logic signed [31:0] center_x_q;
	logic signed [31:0] center_y_q;
	logic signed [31:0] width_x_q;
	logic signed [31:0] width_y_q;
	logic signed [25:0] rotation_degrees_q;
	logic [31:0]        aw_x_q;
	logic [31:0]        aw_y_q;

	// Control.
	logic               accept;
	logic [LAT-1:0]     vld_q;
	logic               wzero;

	// Angle front end.
	logic [UA_W-1:0]    ua;
	logic [UA_W-1:0]    ua_s1;
	logic [UA_W-1:0]    q0_s1;
	logic [D1_W-1:0]    r0_s2;
	logic [D_W-1:0]     d_s3;
	logic [R_W-1:0]     r_s4;
	logic [1:0]         quad_s4;
	logic [XP_W-1:0]    xprod_s5;
	logic [1:0]         quad_s5;
	logic [30:0]        x_s5;
	logic [61:0]        x2prod_s6;
	logic [30:0]        x_s6;
	logic [1:0]         quad_s6;

	// Series and later stages.
	sc_stage_t          sc_a_s [1:SC_TERMS];
	sc_stage_t          sc_b_s [1:SC_TERMS];
	sc_stage_t          sc_c_s [0:SC_TERMS];
	logic signed [31:0] sin_s;
	logic signed [31:0] cos_s;
	logic [30:0]        sc_cl_s;
	logic [30:0]        sc_cl_c;

	point_t             pt_s   [1:SC_LAT];
	side_t              side_s [1:LAT-1];

	logic signed [63:0] pxc_r1, pys_r1, pxs_r1, pyc_r1;
	logic signed [63:0] cxc_r1, cys_r1, cxs_r1, cyc_r1;
	logic signed [33:0] xr_r2, yr_r2, cxr_r2, cyr_r2;
	logic signed [34:0] xc_r3, yc_r3;
	logic [34:0]        adx, ady;

	dv_stage_t          dv_s [0:DIV_BITS];
	logic [30:0]        ux, uy;
	logic [61:0]        usq_x_e1, usq_y_e1;
	logic [38:0]        e_e2;

	nx_stage_t          nx_s [0:EXP_SH_BITS];
	ex_stage_t          ex_a_s [1:EX_TERMS];
	ex_stage_t          ex_b_s [1:EX_TERMS];
	ex_stage_t          ex_c_s [0:EX_TERMS];
	logic [30:0]        g_s;
	logic [30:0]        ex_cl;
	logic signed [63:0] prod_m1;
	logic signed [34:0] model_m2;
	logic signed [35:0] res_full;

	// Handshake: the pipeline never stalls.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_offset_q      <= '0;
			peak_amplitude_q   <= 32'sd65536;
			center_x_q         <= '0;
			center_y_q         <= '0;
			width_x_q          <= 32'sd65536;
			width_y_q          <= 32'sd65536;
			rotation_degrees_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_OFFSET:    base_offset_q      <= cfg_data;
				REG_PEAK_AMPLITUDE: peak_amplitude_q   <= cfg_data;
				REG_CENTER_X:       center_x_q         <= cfg_data;
				REG_CENTER_Y:       center_y_q         <= cfg_data;
				REG_WIDTH_X:        width_x_q          <= cfg_data;
				REG_WIDTH_Y:        width_y_q          <= cfg_data;
				REG_ROTATION:       rotation_degrees_q <= cfg_data[ANGLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Width magnitudes, registered from the width registers.
	always_ff @(posedge clk) begin
		aw_x_q <= (width_x_q < 0) ? 32'(-width_x_q) : 32'(width_x_q);
		aw_y_q <= (width_y_q < 0) ? 32'(-width_y_q) : 32'(width_y_q);
	end

	assign wzero = (width_x_q == '0) || (width_y_q == '0);

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// Point and side data delay lines.
	always_ff @(posedge clk) begin
		pt_s[1]   <= '{px: point_x, py: point_y};
		side_s[1] <= '{meas: measured_value, last: last_point};
	end

	for (genvar k = 2; k <= SC_LAT; k++) begin : g_pt
		always_ff @(posedge clk) begin
			pt_s[k] <= pt_s[k-1];
		end
	end

	for (genvar k = 2; k <= LAT - 1; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[k] <= side_s[k-1];
		end
	end

	// Angle reduction modulo a full turn: reciprocal estimate, then one correction.
	assign ua = UA_W'(rotation_degrees_q) + UA_W'(OFFS);

	always_ff @(posedge clk) begin
		ua_s1 <= ua;
		q0_s1 <= UA_W'(((2 * UA_W)'(ua) * (2 * UA_W)'(M_ANG)) >> UA_W);
		r0_s2 <= D1_W'(ua_s1 - q0_s1 * UA_W'(FULL));
		d_s3  <= (r0_s2 >= D1_W'(FULL)) ? D_W'(r0_s2 - D1_W'(FULL)) : D_W'(r0_s2);
	end

	// Quadrant split and conversion to radians.
	always_ff @(posedge clk) begin
		if (d_s3 >= D_W'(3 * QUARTER)) begin
			quad_s4 <= 2'd3;
			r_s4    <= R_W'(d_s3 - D_W'(3 * QUARTER));
		end else if (d_s3 >= D_W'(2 * QUARTER)) begin
			quad_s4 <= 2'd2;
			r_s4    <= R_W'(d_s3 - D_W'(2 * QUARTER));
		end else if (d_s3 >= D_W'(QUARTER)) begin
			quad_s4 <= 2'd1;
			r_s4    <= R_W'(d_s3 - D_W'(QUARTER));
		end else begin
			quad_s4 <= 2'd0;
			r_s4    <= R_W'(d_s3);
		end
		xprod_s5  <= XP_W'(r_s4) * XP_W'(DEG2RAD_Q32);
		quad_s5   <= quad_s4;
		x2prod_s6 <= 62'(x_s5) * 62'(x_s5);
		x_s6      <= x_s5;
		quad_s6   <= quad_s5;
	end

	assign x_s5 = 31'(xprod_s5 >> (FRAC_BITS + 2));

	// Seed of both series.
	always_comb begin
		sc_c_s[0]       = '0;
		sc_c_s[0].t_s   = 32'(x_s6);
		sc_c_s[0].t_c   = 32'(Q30_ONE);
		sc_c_s[0].acc_s = 34'(x_s6);
		sc_c_s[0].acc_c = 34'(Q30_ONE);
		sc_c_s[0].x2    = x2prod_s6[61:30];
		sc_c_s[0].quad  = quad_s6;
	end

	// Sine and cosine terms: multiply by x^2, divide by the term's constant, accumulate.
	for (genvar k = 1; k <= SC_TERMS; k++) begin : g_sc
		localparam longint      DS = sin_div(k);
		localparam longint      DC = cos_div(k);
		localparam logic [32:0] MS = 33'((longint'(1) << 32) / DS);
		localparam logic [32:0] MC = 33'((longint'(1) << 32) / DC);
		logic [63:0] mul_s, mul_c;
		logic [64:0] rcp_s, rcp_c;
		logic [33:0] rd_s, rd_c;
		logic [31:0] qs, qc;
		sc_stage_t   a_nxt, b_nxt, c_nxt;

		assign mul_s = 64'(sc_c_s[k-1].t_s) * 64'(sc_c_s[k-1].x2);
		assign mul_c = 64'(sc_c_s[k-1].t_c) * 64'(sc_c_s[k-1].x2);
		assign rcp_s = 65'(sc_a_s[k].n_s) * 65'(MS);
		assign rcp_c = 65'(sc_a_s[k].n_c) * 65'(MC);
		assign rd_s  = 34'(sc_b_s[k].n_s) - 34'(sc_b_s[k].q_s) * 34'(DS);
		assign rd_c  = 34'(sc_b_s[k].n_c) - 34'(sc_b_s[k].q_c) * 34'(DC);
		assign qs    = sc_b_s[k].q_s + 32'(rd_s >= 34'(DS));
		assign qc    = sc_b_s[k].q_c + 32'(rd_c >= 34'(DC));

		// Next contents of the three stages of this term.
		always_comb begin
			a_nxt     = sc_c_s[k-1];
			a_nxt.n_s = mul_s[61:30];
			a_nxt.n_c = mul_c[61:30];
			b_nxt     = sc_a_s[k];
			b_nxt.q_s = rcp_s[63:32];
			b_nxt.q_c = rcp_c[63:32];
			c_nxt     = sc_b_s[k];
			c_nxt.t_s = qs;
			c_nxt.t_c = qc;
			if ((k % 2) == 1) begin
				c_nxt.acc_s = sc_b_s[k].acc_s - 34'(qs);
				c_nxt.acc_c = sc_b_s[k].acc_c - 34'(qc);
			end else begin
				c_nxt.acc_s = sc_b_s[k].acc_s + 34'(qs);
				c_nxt.acc_c = sc_b_s[k].acc_c + 34'(qc);
			end
		end

		always_ff @(posedge clk) begin
			sc_a_s[k] <= a_nxt;
			sc_b_s[k] <= b_nxt;
			sc_c_s[k] <= c_nxt;
		end
	end

	// Clamp and map by quadrant.
	assign sc_cl_s = clamp_q30(sc_c_s[SC_TERMS].acc_s);
	assign sc_cl_c = clamp_q30(sc_c_s[SC_TERMS].acc_c);

	always_ff @(posedge clk) begin
		case (sc_c_s[SC_TERMS].quad)
			2'd0: begin
				sin_s <= 32'(sc_cl_s);
				cos_s <= 32'(sc_cl_c);
			end
			2'd1: begin
				sin_s <= 32'(sc_cl_c);
				cos_s <= -32'(sc_cl_s);
			end
			2'd2: begin
				sin_s <= -32'(sc_cl_s);
				cos_s <= -32'(sc_cl_c);
			end
			default: begin
				sin_s <= -32'(sc_cl_c);
				cos_s <= 32'(sc_cl_s);
			end
		endcase
	end

	// Rotation of point and centre: exact products, then floor shift and difference.
	always_ff @(posedge clk) begin
		pxc_r1 <= 64'(pt_s[SC_LAT].px) * 64'(cos_s);
		pys_r1 <= 64'(pt_s[SC_LAT].py) * 64'(sin_s);
		pxs_r1 <= 64'(pt_s[SC_LAT].px) * 64'(sin_s);
		pyc_r1 <= 64'(pt_s[SC_LAT].py) * 64'(cos_s);
		cxc_r1 <= 64'(center_x_q) * 64'(cos_s);
		cys_r1 <= 64'(center_y_q) * 64'(sin_s);
		cxs_r1 <= 64'(center_x_q) * 64'(sin_s);
		cyc_r1 <= 64'(center_y_q) * 64'(cos_s);
		xr_r2  <= 34'((pxc_r1 - pys_r1) >>> 30);
		yr_r2  <= 34'((pxs_r1 + pyc_r1) >>> 30);
		cxr_r2 <= 34'((cxc_r1 - cys_r1) >>> 30);
		cyr_r2 <= 34'((cxs_r1 + cyc_r1) >>> 30);
		xc_r3  <= 35'(xr_r2) - 35'(cxr_r2);
		yc_r3  <= 35'(yr_r2) - 35'(cyr_r2);
	end

	// Distance magnitudes, saturation test and divider seed.
	assign adx = (xc_r3 < 0) ? 35'(-xc_r3) : 35'(xc_r3);
	assign ady = (yc_r3 < 0) ? 35'(-yc_r3) : 35'(yc_r3);

	always_ff @(posedge clk) begin
		dv_s[0] <= '{r_x: {adx, 26'd0}, r_y: {ady, 26'd0}, q_x: '0, q_y: '0,
			sat_x: 36'(adx) >= {aw_x_q, 4'd0}, sat_y: 36'(ady) >= {aw_y_q, 4'd0}};
	end

	// Restoring division, one quotient bit per stage, both axes side by side.
	for (genvar j = 1; j <= DIV_BITS; j++) begin : g_div
		localparam int B = DIV_BITS - j;
		logic [60:0] dsx, dsy;
		dv_stage_t   dv_nxt;

		assign dsx = 61'(aw_x_q) << B;
		assign dsy = 61'(aw_y_q) << B;

		always_comb begin
			dv_nxt = dv_s[j-1];
			if (dv_s[j-1].r_x >= dsx) begin
				dv_nxt.r_x    = dv_s[j-1].r_x - dsx;
				dv_nxt.q_x[B] = 1'b1;
			end
			if (dv_s[j-1].r_y >= dsy) begin
				dv_nxt.r_y    = dv_s[j-1].r_y - dsy;
				dv_nxt.q_y[B] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			dv_s[j] <= dv_nxt;
		end
	end

	// Squared normalised distances and half their sum in Q30.
	assign ux = dv_s[DIV_BITS].sat_x ? 31'(Q30_ONE) : {1'b0, dv_s[DIV_BITS].q_x};
	assign uy = dv_s[DIV_BITS].sat_y ? 31'(Q30_ONE) : {1'b0, dv_s[DIV_BITS].q_y};

	always_ff @(posedge clk) begin
		usq_x_e1 <= 62'(ux) * 62'(ux);
		usq_y_e1 <= 62'(uy) * 62'(uy);
		e_e2     <= {36'(usq_x_e1[61:26]) + 36'(usq_y_e1[61:26]), 3'd0};
		nx_s[0]  <= '{r: e_e2, sh: '0, big: 39'(e_e2) >= 39'(LN2_BIG)};
	end

	// Range reduction by ln2: shift count found one bit per stage.
	for (genvar j = 1; j <= EXP_SH_BITS; j++) begin : g_ln2
		localparam int B = EXP_SH_BITS - j;
		localparam logic [38:0] LN2_SH = 39'(LN2_Q30 << B);
		nx_stage_t nx_nxt;

		always_comb begin
			nx_nxt = nx_s[j-1];
			if (nx_s[j-1].r >= LN2_SH) begin
				nx_nxt.r     = nx_s[j-1].r - LN2_SH;
				nx_nxt.sh[B] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			nx_s[j] <= nx_nxt;
		end
	end

	// Seed of the exponential series.
	always_comb begin
		ex_c_s[0]      = '0;
		ex_c_s[0].term = 32'(Q30_ONE);
		ex_c_s[0].acc  = 34'(Q30_ONE);
		ex_c_s[0].rem  = nx_s[EXP_SH_BITS].r[29:0];
		ex_c_s[0].sh   = nx_s[EXP_SH_BITS].sh;
		ex_c_s[0].big  = nx_s[EXP_SH_BITS].big;
	end

	// Terms of exp(-rem): multiply by rem, divide by k, accumulate with alternating sign.
	for (genvar k = 1; k <= EX_TERMS; k++) begin : g_ex
		localparam longint      DE = longint'(k);
		localparam logic [32:0] ME = 33'((longint'(1) << 32) / DE);
		logic [63:0] mul_e;
		logic [64:0] rcp_e;
		logic [33:0] rd_e;
		logic [31:0] qe;
		ex_stage_t   a_nxt, b_nxt, c_nxt;

		assign mul_e = 64'(ex_c_s[k-1].term) * 64'(ex_c_s[k-1].rem);
		assign rcp_e = 65'(ex_a_s[k].n) * 65'(ME);
		assign rd_e  = 34'(ex_b_s[k].n) - 34'(ex_b_s[k].q0) * 34'(DE);
		assign qe    = ex_b_s[k].q0 + 32'(rd_e >= 34'(DE));

		// Next contents of the three stages of this term.
		always_comb begin
			a_nxt      = ex_c_s[k-1];
			a_nxt.n    = mul_e[61:30];
			b_nxt      = ex_a_s[k];
			b_nxt.q0   = rcp_e[63:32];
			c_nxt      = ex_b_s[k];
			c_nxt.term = qe;
			if ((k % 2) == 1) begin
				c_nxt.acc = ex_b_s[k].acc - 34'(qe);
			end else begin
				c_nxt.acc = ex_b_s[k].acc + 34'(qe);
			end
		end

		always_ff @(posedge clk) begin
			ex_a_s[k] <= a_nxt;
			ex_b_s[k] <= b_nxt;
			ex_c_s[k] <= c_nxt;
		end
	end

	// Gaussian factor, model and saturated residual.
	assign ex_cl    = clamp_q30(ex_c_s[EX_TERMS].acc);
	assign res_full = 36'(side_s[LAT-1].meas) - 36'(model_m2);

	always_ff @(posedge clk) begin
		g_s      <= ex_c_s[EX_TERMS].big ? '0 : (ex_cl >> ex_c_s[EX_TERMS].sh);
		prod_m1  <= 64'(peak_amplitude_q) * 64'($signed({1'b0, g_s}));
		model_m2 <= 35'(base_offset_q) + 35'(prod_m1 >>> 30);
		last_result <= side_s[LAT-1].last;
		if (wzero) begin
			residual   <= 32'sh7FFFFFFF;
			range_flag <= 1'b1;
		end else if (res_full > RES_MAX) begin
			residual   <= 32'(RES_MAX);
			range_flag <= 1'b1;
		end else if (res_full < RES_MIN) begin
			residual   <= 32'(RES_MIN);
			range_flag <= 1'b1;
		end else begin
			residual   <= 32'(res_full);
			range_flag <= 1'b0;
		end
	end

	assign result_valid = vld_q[LAT-1];

	// Checks on the pipeline.
	`RG2D_ASSERT_IMP(a_result_had_point, result_valid, $past(accept, LAT))
	`RG2D_ASSERT_IMP(a_flag_means_limit, result_valid && range_flag && !wzero, residual == 32'sh7FFFFFFF || residual == -32'sh80000000)
	`RG2D_ASSERT_NXT(a_far_point_zero, ex_c_s[EX_TERMS].big, g_s == '0)

endmodule
